>>> hw/rtl/assert_macros.svh
// Assertion macros for the token classifier RTL, used by cst_back.
// Define NO_ASSERTIONS to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CST_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CST_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define CST_ASSERT(label, clk, rst, prop, msg)
`define CST_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

>>> hw/rtl/cst_pkg.sv
// Shared types, constants and character tests of the token classifier.
// Has no dependencies; every other file but assert_macros.svh imports it.
`timescale 1ns / 1ps
package cst_pkg;

   localparam int CHAR_W = 8;
   localparam int POS_W  = 12;
   localparam int KIND_W = 3;

   localparam int DEFAULT_MAX_LINE_LENGTH = 4096;
   localparam int DEFAULT_QUEUE_DEPTH     = 4;

   localparam logic [KIND_W-1:0] KIND_INT       = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REAL      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_IDENT     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BAD_IDENT = 3'd3;
   localparam logic [KIND_W-1:0] KIND_OPER      = 3'd4;

   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_EQUAL = 8'h3D;
   localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
   localparam logic [CHAR_W-1:0] CH_LESS  = 8'h3C;
   localparam logic [CHAR_W-1:0] CH_MORE  = 8'h3E;
   localparam logic [CHAR_W-1:0] CH_LPAR  = 8'h28;
   localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;
   localparam logic [CHAR_W-1:0] CH_LBRK  = 8'h5B;
   localparam logic [CHAR_W-1:0] CH_RBRK  = 8'h5D;
   localparam logic [CHAR_W-1:0] CH_LBRC  = 8'h7B;
   localparam logic [CHAR_W-1:0] CH_RBRC  = 8'h7D;
   localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

   // One queue entry holds every result caused by one input beat.
   typedef struct packed {
      logic              has_word;
      logic [KIND_W-1:0] word_kind;
      logic [POS_W-1:0]  word_start;
      logic [POS_W-1:0]  word_length;
      logic              has_oper;
      logic [POS_W-1:0]  oper_start;
      logic [CHAR_W-1:0] oper_char;
   } cst_entry_type;

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_operator(input logic [CHAR_W-1:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
             (c == CH_SLASH) || (c == CH_EQUAL);
   endfunction

   function automatic logic is_delimiter(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || is_operator(c) || (c == CH_COMMA) || (c == CH_SEMI) ||
             (c == CH_LESS) || (c == CH_MORE) || (c == CH_LPAR) || (c == CH_RPAR) ||
             (c == CH_LBRK) || (c == CH_RBRK) || (c == CH_LBRC) || (c == CH_RBRC);
   endfunction

   function automatic logic [KIND_W-1:0] word_kind(input logic all_digits,
                                                   input logic all_digits_or_dots,
                                                   input logic seen_dot,
                                                   input logic first_is_digit);
      logic [KIND_W-1:0] kind;
      priority if (all_digits) begin
         kind = KIND_INT;
      end else if (all_digits_or_dots && seen_dot) begin
         kind = KIND_REAL;
      end else if (!first_is_digit) begin
         kind = KIND_IDENT;
      end else begin
         kind = KIND_BAD_IDENT;
      end
      return kind;
   endfunction

endpackage

>>> hw/rtl/cst_if.sv
// Valid/ready channel interfaces for the character input and the token output.
// Depends on cst_pkg.
`timescale 1ns / 1ps
interface cst_req_if
   import cst_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_in;
   logic              line_end;

   modport source (output valid, output char_in, output line_end, input ready);
   modport sink   (input valid, input char_in, input line_end, output ready);
endinterface

interface cst_rsp_if
   import cst_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] token_kind;
   logic [POS_W-1:0]  token_start;
   logic [POS_W-1:0]  token_length;
   logic [CHAR_W-1:0] operator_char;
   logic              last_of_run;

   modport source (output valid, output token_kind, output token_start,
                   output token_length, output operator_char, output last_of_run,
                   input ready);
   modport sink   (input valid, input token_kind, input token_start,
                   input token_length, input operator_char, input last_of_run,
                   output ready);
endinterface

>>> hw/rtl/cst_front.sv
// Front end: accepts characters, tracks the open word and line position,
// and pushes one queue entry per beat that closes a word or is an operator.
`timescale 1ns / 1ps
module cst_front
   import cst_pkg::*;
#(
   parameter int MAX_LINE_LENGTH = DEFAULT_MAX_LINE_LENGTH
) (
   input  logic          clock,
   input  logic          reset,
   cst_req_if.sink       req_ch,
   output logic          push_valid,
   output cst_entry_type push_entry,
   input  logic          push_ready
);

   localparam int POS_CAP_INT = (MAX_LINE_LENGTH - 1 < 4095) ? MAX_LINE_LENGTH - 1 : 4095;
   localparam int LEN_CAP_INT = (MAX_LINE_LENGTH < 4095) ? MAX_LINE_LENGTH : 4095;
   localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_CAP_INT);
   localparam logic [POS_W-1:0] LEN_CAP = POS_W'(LEN_CAP_INT);

   logic [POS_W-1:0] line_pos_ff, line_pos_in;
   logic [POS_W-1:0] word_start_ff, word_start_in;
   logic [POS_W-1:0] word_len_ff, word_len_in;
   logic             first_digit_ff, first_digit_in;
   logic             all_digits_ff, all_digits_in;
   logic             digits_dots_ff, digits_dots_in;
   logic             seen_dot_ff, seen_dot_in;

   logic             accept;
   logic             delim;
   logic             digit;
   logic             dot;
   logic             fresh;
   logic [POS_W-1:0] grow_start;
   logic [POS_W-1:0] grow_len;
   logic             grow_first;
   logic             grow_digits;
   logic             grow_dd;
   logic             grow_dot;

   assign accept = req_ch.valid && push_ready;
   assign req_ch.ready = push_ready;

   always_comb begin
      delim       = is_delimiter(req_ch.char_in);
      digit       = is_digit(req_ch.char_in);
      dot         = (req_ch.char_in == CH_DOT);
      fresh       = (word_len_ff == '0);
      grow_start  = fresh ? line_pos_ff : word_start_ff;
      grow_first  = fresh ? digit : first_digit_ff;
      grow_digits = all_digits_ff && digit;
      grow_dd     = digits_dots_ff && (digit || dot);
      grow_dot    = seen_dot_ff || dot;
      grow_len    = (word_len_ff < LEN_CAP) ? word_len_ff + POS_W'(1) : word_len_ff;

      push_entry = '0;
      if (delim) begin
         push_entry.has_word    = !fresh;
         push_entry.word_kind   = word_kind(all_digits_ff, digits_dots_ff, seen_dot_ff,
                                            first_digit_ff);
         push_entry.word_start  = word_start_ff;
         push_entry.word_length = word_len_ff;
         push_entry.has_oper    = is_operator(req_ch.char_in);
         push_entry.oper_start  = line_pos_ff;
         push_entry.oper_char   = req_ch.char_in;
      end else begin
         push_entry.has_word    = req_ch.line_end;
         push_entry.word_kind   = word_kind(grow_digits, grow_dd, grow_dot, grow_first);
         push_entry.word_start  = grow_start;
         push_entry.word_length = grow_len;
      end
      push_valid = req_ch.valid && (push_entry.has_word || push_entry.has_oper);

      line_pos_in    = line_pos_ff;
      word_start_in  = word_start_ff;
      word_len_in    = word_len_ff;
      first_digit_in = first_digit_ff;
      all_digits_in  = all_digits_ff;
      digits_dots_in = digits_dots_ff;
      seen_dot_in    = seen_dot_ff;
      if (accept) begin
         if (req_ch.line_end || delim) begin
            word_start_in  = '0;
            word_len_in    = '0;
            first_digit_in = 1'b0;
            all_digits_in  = 1'b1;
            digits_dots_in = 1'b1;
            seen_dot_in    = 1'b0;
         end else begin
            word_start_in  = grow_start;
            word_len_in    = grow_len;
            first_digit_in = grow_first;
            all_digits_in  = grow_digits;
            digits_dots_in = grow_dd;
            seen_dot_in    = grow_dot;
         end
         if (req_ch.line_end) begin
            line_pos_in = '0;
         end else if (line_pos_ff < POS_CAP) begin
            line_pos_in = line_pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_pos_ff    <= '0;
         word_start_ff  <= '0;
         word_len_ff    <= '0;
         first_digit_ff <= 1'b0;
         all_digits_ff  <= 1'b1;
         digits_dots_ff <= 1'b1;
         seen_dot_ff    <= 1'b0;
      end else begin
         line_pos_ff    <= line_pos_in;
         word_start_ff  <= word_start_in;
         word_len_ff    <= word_len_in;
         first_digit_ff <= first_digit_in;
         all_digits_ff  <= all_digits_in;
         digits_dots_ff <= digits_dots_in;
         seen_dot_ff    <= seen_dot_in;
      end
   end

endmodule

>>> hw/rtl/cst_queue.sv
// Short register queue between the front end and the output stage.
// Depends on cst_pkg for the entry type.
`timescale 1ns / 1ps
module cst_queue
   import cst_pkg::*;
#(
   parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  cst_entry_type push_entry,
   output logic          push_ready,
   output logic          pop_valid,
   output cst_entry_type pop_entry,
   input  logic          pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   cst_entry_type    slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> hw/rtl/cst_back.sv
// Output stage: unpacks queue entries into one token per beat, the word token
// before the operator token, through a registered output. Depends on cst_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cst_back
   import cst_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          pop_valid,
   input  cst_entry_type pop_entry,
   output logic          pop,
   cst_rsp_if.source     rsp_ch
);

   logic              out_valid_ff, out_valid_in;
   logic [KIND_W-1:0] out_kind_ff, out_kind_in;
   logic [POS_W-1:0]  out_start_ff, out_start_in;
   logic [POS_W-1:0]  out_len_ff, out_len_in;
   logic [CHAR_W-1:0] out_char_ff, out_char_in;
   logic              out_last_ff, out_last_in;
   logic              oper_pend_ff, oper_pend_in;
   logic [POS_W-1:0]  oper_start_ff, oper_start_in;
   logic [CHAR_W-1:0] oper_char_ff, oper_char_in;
   logic              load;

   assign load = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_kind_in   = out_kind_ff;
      out_start_in  = out_start_ff;
      out_len_in    = out_len_ff;
      out_char_in   = out_char_ff;
      out_last_in   = out_last_ff;
      oper_pend_in  = oper_pend_ff;
      oper_start_in = oper_start_ff;
      oper_char_in  = oper_char_ff;
      pop           = 1'b0;
      if (load) begin
         priority if (oper_pend_ff) begin
            out_valid_in = 1'b1;
            out_kind_in  = KIND_OPER;
            out_start_in = oper_start_ff;
            out_len_in   = POS_W'(1);
            out_char_in  = oper_char_ff;
            out_last_in  = 1'b1;
            oper_pend_in = 1'b0;
         end else if (pop_valid) begin
            pop          = 1'b1;
            out_valid_in = 1'b1;
            if (pop_entry.has_word) begin
               out_kind_in   = pop_entry.word_kind;
               out_start_in  = pop_entry.word_start;
               out_len_in    = pop_entry.word_length;
               out_char_in   = '0;
               out_last_in   = !pop_entry.has_oper;
               oper_pend_in  = pop_entry.has_oper;
               oper_start_in = pop_entry.oper_start;
               oper_char_in  = pop_entry.oper_char;
            end else begin
               out_kind_in  = KIND_OPER;
               out_start_in = pop_entry.oper_start;
               out_len_in   = POS_W'(1);
               out_char_in  = pop_entry.oper_char;
               out_last_in  = 1'b1;
            end
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         oper_pend_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         oper_pend_ff <= oper_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff   <= out_kind_in;
      out_start_ff  <= out_start_in;
      out_len_ff    <= out_len_in;
      out_char_ff   <= out_char_in;
      out_last_ff   <= out_last_in;
      oper_start_ff <= oper_start_in;
      oper_char_ff  <= oper_char_in;
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.token_kind    = out_kind_ff;
   assign rsp_ch.token_start   = out_start_ff;
   assign rsp_ch.token_length  = out_len_ff;
   assign rsp_ch.operator_char = out_char_ff;
   assign rsp_ch.last_of_run   = out_last_ff;

   // A held operator always follows a word beat that is not the last of its run.
   `CST_ASSERT(a_pend_after_word, clock, reset, oper_pend_ff |-> out_valid_ff && !out_last_ff, "operator pending without word beat")
   `CST_ASSERT(a_oper_is_last, clock, reset, out_valid_ff && out_kind_ff == KIND_OPER |-> out_last_ff && out_len_ff == POS_W'(1), "operator beat malformed")
   `CST_ASSERT_NEVER(a_empty_entry, clock, reset, pop_valid && !pop_entry.has_word && !pop_entry.has_oper, "queue entry carries no token")
   `CST_ASSERT_NEVER(a_pop_while_pend, clock, reset, pop && oper_pend_ff, "queue popped while operator pending")

endmodule

>>> hw/rtl/char_stream_token_classifier.sv
// Character stream token classifier: takes one byte of a source line per beat and
// returns word tokens (integer, real, identifier, invalid identifier) and operator
// tokens. A new byte is accepted every cycle while the queue has room. A byte that
// closes a word and is itself an operator causes two tokens, word token first; the
// output stage sends at most one token per cycle, and the queue between the front end
// and the output stage (QUEUE_DEPTH entries) absorbs such bursts, so input stalls only
// when the queue fills. Each token is registered in a queue slot and then in the
// output register. Depends on cst_pkg, cst_if, cst_front, cst_queue and cst_back.
`timescale 1ns / 1ps
module char_stream_token_classifier
   import cst_pkg::*;
#(
   parameter int MAX_LINE_LENGTH = DEFAULT_MAX_LINE_LENGTH,
   parameter int QUEUE_DEPTH     = DEFAULT_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   cst_req_if.sink   req_ch,
   cst_rsp_if.source rsp_ch
);

   logic          push_valid;
   logic          push_ready;
   cst_entry_type push_entry;
   logic          pop_valid;
   logic          pop;
   cst_entry_type pop_entry;

   cst_front #(
      .MAX_LINE_LENGTH(MAX_LINE_LENGTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .push_valid(push_valid),
      .push_entry(push_entry),
      .push_ready(push_ready)
   );

   cst_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_entry(push_entry),
      .push_ready(push_ready),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop       (pop)
   );

   cst_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_valid(pop_valid),
      .pop_entry(pop_entry),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

>>> tb/char_stream_token_classifier_tb.sv
// Self-checking testbench for the character stream token classifier.
// Drives bytes through cst_req_if, checks tokens from cst_rsp_if against a local model.
// Depends on cst_pkg, cst_if and the char_stream_token_classifier RTL.
`timescale 1ns / 1ps
module char_stream_token_classifier_tb;
   import cst_pkg::*;

   localparam int POS_CAP = (DEFAULT_MAX_LINE_LENGTH - 1 < 4095) ?
                            DEFAULT_MAX_LINE_LENGTH - 1 : 4095;
   localparam int LEN_CAP = (DEFAULT_MAX_LINE_LENGTH < 4095) ? DEFAULT_MAX_LINE_LENGTH : 4095;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 16;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [POS_W-1:0]  start;
      logic [POS_W-1:0]  length;
      logic [CHAR_W-1:0] op;
      logic              last;
   } token_type;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              eol;
      logic              typed;
      logic [1:0]        count;
      token_type         tok_a;
      token_type         tok_b;
   } beat_row_type;

   logic clock;
   logic reset;

   cst_req_if req_ch();
   cst_rsp_if rsp_ch();

   char_stream_token_classifier uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   token_type         expected_tokens[$];
   logic [CHAR_W-1:0] line_bytes[$];
   beat_row_type      cur_row;
   int                send_idle;
   int                recv_idle;
   int                bytes_in;
   int                lines_in;
   int                tokens_checked;
   int                mismatches;
   int                quiet_cycles;

   int unsigned line_pos;
   int unsigned word_start;
   int unsigned word_len;
   bit          first_digit;
   bit          only_digits;
   bit          only_digits_dots;
   bit          dot_seen;

   initial clock = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit is_number_char(input logic [CHAR_W-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic bit is_arith_op(input logic [CHAR_W-1:0] c);
      case (c)
         CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQUAL: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit is_separator(input logic [CHAR_W-1:0] c);
      case (c)
         CH_SPACE, CH_COMMA, CH_SEMI, CH_LESS, CH_MORE, CH_LPAR, CH_RPAR,
         CH_LBRK, CH_RBRK, CH_LBRC, CH_RBRC: return 1'b1;
         default: return is_arith_op(c);
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] pick_separator();
      case ($urandom_range(0, 15))
         0: return CH_SPACE;
         1: return CH_PLUS;
         2: return CH_MINUS;
         3: return CH_STAR;
         4: return CH_SLASH;
         5: return CH_EQUAL;
         6: return CH_COMMA;
         7: return CH_SEMI;
         8: return CH_LESS;
         9: return CH_MORE;
         10: return CH_LPAR;
         11: return CH_RPAR;
         12: return CH_LBRK;
         13: return CH_RBRK;
         14: return CH_LBRC;
         default: return CH_RBRC;
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] digit();
      return CHAR_W'(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
   endfunction

   function automatic logic [CHAR_W-1:0] letter();
      case ($urandom_range(0, 2))
         0: return CHAR_W'("a" + CHAR_W'($urandom_range(0, 25)));
         1: return CHAR_W'("A" + CHAR_W'($urandom_range(0, 25)));
         default: return "_";
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] ident_char();
      case ($urandom_range(0, 3))
         0: return digit();
         1: return CH_DOT;
         default: return letter();
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] word_byte();
      logic [CHAR_W-1:0] c;
      do c = CHAR_W'($urandom_range(0, 255)); while (is_separator(c));
      return c;
   endfunction

   function automatic token_type tok(input logic [KIND_W-1:0] kind, input int start,
                                     input int length, input logic [CHAR_W-1:0] op,
                                     input logic last);
      token_type t;
      t.kind   = kind;
      t.start  = POS_W'(start);
      t.length = POS_W'(length);
      t.op     = op;
      t.last   = last;
      return t;
   endfunction

   function automatic beat_row_type row_of(input logic [CHAR_W-1:0] c, input logic eol);
      beat_row_type r;
      r       = '0;
      r.ch    = c;
      r.eol   = eol;
      return r;
   endfunction

   function automatic beat_row_type typed_row(input logic [CHAR_W-1:0] c, input logic eol,
                                              input int count, input token_type a,
                                              input token_type b);
      beat_row_type r;
      r       = row_of(c, eol);
      r.typed = 1'b1;
      r.count = 2'(count);
      r.tok_a = a;
      r.tok_b = b;
      return r;
   endfunction

   task automatic clear_word_state();
      word_start       = 0;
      word_len         = 0;
      first_digit      = 1'b0;
      only_digits      = 1'b1;
      only_digits_dots = 1'b1;
      dot_seen         = 1'b0;
   endtask

   task automatic predict_tokens(input logic [CHAR_W-1:0] c, input logic eol, input bit keep);
      token_type word_tok;
      token_type oper_tok;
      bit        has_word;
      bit        has_oper;
      word_tok = '0;
      oper_tok = '0;
      has_oper = 1'b0;
      if (is_separator(c)) begin
         has_word = (word_len != 0);
         has_oper = is_arith_op(c);
         oper_tok = tok(KIND_OPER, int'(line_pos), 1, c, 1'b0);
      end else begin
         if (word_len == 0) begin
            word_start  = line_pos;
            first_digit = is_number_char(c);
         end
         if (!is_number_char(c)) only_digits = 1'b0;
         if (!is_number_char(c) && c != CH_DOT) only_digits_dots = 1'b0;
         if (c == CH_DOT) dot_seen = 1'b1;
         if (word_len < LEN_CAP) word_len++;
         has_word = eol;
      end
      if (has_word) begin
         word_tok.kind   = only_digits ? KIND_INT :
                           (only_digits_dots && dot_seen) ? KIND_REAL :
                           !first_digit ? KIND_IDENT : KIND_BAD_IDENT;
         word_tok.start  = word_start[POS_W-1:0];
         word_tok.length = word_len[POS_W-1:0];
         clear_word_state();
      end
      if (eol) begin
         line_pos = 0;
         clear_word_state();
      end else if (line_pos < POS_CAP) begin
         line_pos++;
      end
      if (has_oper) oper_tok.last = 1'b1;
      else word_tok.last = 1'b1;
      if (keep && has_word) expected_tokens.push_back(word_tok);
      if (keep && has_oper) expected_tokens.push_back(oper_tok);
   endtask

   // Called just after a falling edge; returns just after the falling edge that follows the
   // beat's acceptance.
   task automatic send_beat(input beat_row_type row);
      while ($urandom_range(0, 99) < send_idle) begin
         req_ch.valid    <= 1'b0;
         req_ch.char_in  <= CHAR_W'($urandom_range(0, 255));
         req_ch.line_end <= 1'($urandom_range(0, 1));
         @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.char_in  <= row.ch;
      req_ch.line_end <= row.eol;
      cur_row         <= row;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      bytes_in++;
      if (row.eol) lines_in++;
      @(negedge clock);
   endtask

   task automatic add_word(input int style);
      case (style)
         0: begin
            repeat ($urandom_range(1, 5)) line_bytes.push_back(digit());
         end
         1: begin
            repeat ($urandom_range(0, 3)) line_bytes.push_back(digit());
            line_bytes.push_back(CH_DOT);
            repeat ($urandom_range(0, 3)) line_bytes.push_back(digit());
            if ($urandom_range(0, 3) == 0) line_bytes.push_back(CH_DOT);
         end
         2: begin
            line_bytes.push_back(letter());
            repeat ($urandom_range(0, 5)) line_bytes.push_back(ident_char());
         end
         3: begin
            line_bytes.push_back(digit());
            line_bytes.push_back(letter());
            repeat ($urandom_range(0, 4)) line_bytes.push_back(ident_char());
         end
         default: begin
            repeat ($urandom_range(1, 4)) line_bytes.push_back(word_byte());
         end
      endcase
   endtask

   // Mostly lines of well-formed words and delimiters; about one in five is raw noise.
   task automatic send_lines(input int upto);
      while (bytes_in < upto) begin
         line_bytes.delete();
         if ($urandom_range(0, 99) < 20) begin
            repeat ($urandom_range(1, 12)) line_bytes.push_back(CHAR_W'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 5)) begin
               repeat ($urandom_range(0, 2)) line_bytes.push_back(pick_separator());
               add_word($urandom_range(0, 4));
            end
            if ($urandom_range(0, 1) == 1) line_bytes.push_back(pick_separator());
         end
         foreach (line_bytes[i]) send_beat(row_of(line_bytes[i], i == line_bytes.size() - 1));
      end
   endtask

   always @(negedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(0, 99) >= recv_idle);
   end

   always @(posedge clock) begin
      token_type got;
      token_type want;
      bit        moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            moved = 1'b1;
            predict_tokens(req_ch.char_in, req_ch.line_end, !cur_row.typed);
            if (cur_row.typed && cur_row.count > 0) expected_tokens.push_back(cur_row.tok_a);
            if (cur_row.typed && cur_row.count > 1) expected_tokens.push_back(cur_row.tok_b);
         end
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            moved       = 1'b1;
            got.kind    = rsp_ch.token_kind;
            got.start   = rsp_ch.token_start;
            got.length  = rsp_ch.token_length;
            got.op      = rsp_ch.operator_char;
            got.last    = rsp_ch.last_of_run;
            if (expected_tokens.size() == 0) begin
               $error("unexpected token: kind %0d start %0d length %0d",
                      got.kind, got.start, got.length);
               mismatches++;
            end else begin
               want = expected_tokens.pop_front();
               tokens_checked++;
               if (got.kind !== want.kind) begin
                  $error("token_kind: expected %0d, got %0d", want.kind, got.kind);
                  mismatches++;
               end
               if (got.start !== want.start) begin
                  $error("token_start: expected %0d, got %0d", want.start, got.start);
                  mismatches++;
               end
               if (got.length !== want.length) begin
                  $error("token_length: expected %0d, got %0d", want.length, got.length);
                  mismatches++;
               end
               if (got.op !== want.op) begin
                  $error("operator_char: expected %0d, got %0d", want.op, got.op);
                  mismatches++;
               end
               if (got.last !== want.last) begin
                  $error("last_of_run: expected %0d, got %0d", want.last, got.last);
                  mismatches++;
               end
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d idle cycles, %0d tokens outstanding",
                     quiet_cycles, expected_tokens.size());
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      beat_row_type directed [0:21];
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.char_in  = '0;
      req_ch.line_end = 1'b0;
      rsp_ch.ready    = 1'b0;
      cur_row         = '0;
      send_idle       = 13;
      recv_idle       = 82;
      bytes_in        = 0;
      lines_in        = 0;
      tokens_checked  = 0;
      mismatches      = 0;
      quiet_cycles    = 0;
      line_pos        = 0;
      clear_word_state();

      // The word and operator tokens of untyped rows come from the local model.
      directed = '{
         typed_row("9", 1'b1, 1, tok(KIND_INT, 0, 1, 8'h00, 1'b1), '0),
         typed_row(CH_PLUS, 1'b1, 1, tok(KIND_OPER, 0, 1, CH_PLUS, 1'b1), '0),
         row_of("a", 1'b0), row_of(CH_DOT, 1'b0), row_of("5", 1'b0), row_of(CH_MINUS, 1'b0),
         row_of(CH_DOT, 1'b0), row_of(CH_DOT, 1'b0), row_of(CH_SPACE, 1'b0),
         row_of("1", 1'b0), row_of(CH_DOT, 1'b0), row_of("2", 1'b0), row_of(CH_STAR, 1'b0),
         row_of("7", 1'b0), row_of("x", 1'b0), row_of(CH_SLASH, 1'b0),
         row_of(8'h00, 1'b0), row_of(CH_EQUAL, 1'b0), row_of(8'hFF, 1'b1),
         typed_row(CH_COMMA, 1'b1, 0, '0, '0),
         row_of("3", 1'b0),
         typed_row(CH_SEMI, 1'b1, 1, tok(KIND_INT, 0, 1, 8'h00, 1'b1), '0)
      };

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_beat(directed[i]);
      send_lines(330);
      send_idle = 82;
      recv_idle = 13;
      send_lines(650);
      send_idle = 0;
      recv_idle = 0;
      send_lines(950);
      req_ch.valid <= 1'b0;

      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d bytes over %0d lines: directed rows, then random lines in three stall phases",
               bytes_in, lines_in);
      $display("%0d tokens compared, %0d field mismatches", tokens_checked, mismatches);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
